// ----- src/priority_admission_mailbox_unit_assert.svh -----
// Assertion macros shared by the mailbox checker.
`ifndef PRIORITY_ADMISSION_MAILBOX_UNIT_ASSERT_SVH
`define PRIORITY_ADMISSION_MAILBOX_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define PAM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mailbox assertion failed");

// Next-cycle implication, switched off while reset is asserted.
`define PAM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mailbox assertion failed");

// Same-cycle implication that is also checked during reset.
`define PAM_ASSERT_ALWAYS(label, ante, cons) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("mailbox assertion failed");

`endif

// ----- src/pam_pkg.sv -----
package pam_pkg;

	// Width of the envelope count register and its largest value.
	localparam int CFG_W = 3;
	localparam int ENV_MAX = (1 << CFG_W) - 1;

	// Width of the priority fields on the ports.
	localparam int PRI_PORT_W = 2;

	// Widest internal priority, enough for eight levels.
	localparam int PRI_MAX_W = 3;

	// Operation codes.
	localparam logic CMD_SEND = 1'b0;
	localparam logic CMD_RECV = 1'b1;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_ENQUEUED = 3'd0,
		ST_PARKED   = 3'd1,
		ST_REJECTED = 3'd2,
		ST_RECEIVED = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// Control part of one result word.
	typedef struct packed {
		status_t                status;
		logic                   promoted_valid;
		logic [PRI_MAX_W-1:0]   promoted_priority;
	} result_t;

endpackage

// ----- src/pam_ram.sv -----
module pam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 12
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Single write port, registered read port that holds its data between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/pam_ctrl.sv -----
module pam_ctrl #(
	parameter int MAILBOX_DEPTH = 4,
	parameter int WAIT_DEPTH = 4,
	parameter int PRIORITY_LEVELS = 3,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pam_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                          step,
	input  logic                          cmd,
	input  logic [pam_pkg::PRI_PORT_W-1:0] pri,
	input  logic [DATA_WIDTH-1:0]         msg,
	output pam_pkg::result_t              res,
	output logic [DATA_WIDTH-1:0]         msg_out
);

	// At most ENV_MAX messages are ever queued, so the ring never needs more slots.
	localparam int QDEPTH = (MAILBOX_DEPTH < pam_pkg::ENV_MAX) ? MAILBOX_DEPTH
		: pam_pkg::ENV_MAX;
	localparam int QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QSUM_W = pam_pkg::CFG_W + 1;
	localparam int WIDX_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
	localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);
	localparam int WSUM_W = WCNT_W + 1;
	localparam int WENT = PRIORITY_LEVELS * WAIT_DEPTH;
	localparam int WADDR_W = $clog2(WENT);
	localparam int PRI_W = $clog2(PRIORITY_LEVELS);
	localparam int RST_FREE = (MAILBOX_DEPTH < 4) ? MAILBOX_DEPTH : 4;

	// Mailbox queue state.
	logic [DATA_WIDTH-1:0]       q_store_q [QDEPTH];
	logic [QIDX_W-1:0]           q_head_q;
	logic [pam_pkg::CFG_W-1:0]   q_fill_q;
	logic [pam_pkg::CFG_W-1:0]   free_q;

	// Waiter ring pointers, one ring per priority.
	logic [WIDX_W-1:0]           w_head_q [PRIORITY_LEVELS];
	logic [WCNT_W-1:0]           w_fill_q [PRIORITY_LEVELS];

	// A promoted word lands in the queue in the next cycle, once the RAM has read it.
	logic                        pend_q;
	logic [QIDX_W-1:0]           pend_slot_q;

	logic [pam_pkg::CFG_W-1:0]   eff_count;
	logic [PRI_W-1:0]            sp;
	logic [QSUM_W-1:0]           tail_sum;
	logic [QIDX_W-1:0]           tail;
	logic [QIDX_W-1:0]           head_inc;
	logic [DATA_WIDTH-1:0]       head_data;
	logic [WSUM_W-1:0]           wslot_sum;
	logic [WIDX_W-1:0]           wslot;
	logic                        enq_ok;
	logic                        park_ok;
	logic                        q_empty;
	logic                        pick_valid;
	logic [PRI_W-1:0]            pick_p;
	logic [WIDX_W-1:0]           pick_head;
	logic [WIDX_W-1:0]           pick_head_inc;
	logic                        is_send;
	logic                        do_enq;
	logic                        do_park;
	logic                        do_recv;
	logic                        do_promote;
	logic                        ram_we;
	logic                        ram_re;
	logic [WADDR_W-1:0]          ram_waddr;
	logic [WADDR_W-1:0]          ram_raddr;
	logic [DATA_WIDTH-1:0]       ram_rdata;

	// Envelope count clamped to the range the mailbox can hold.
	always_comb begin
		if (cfg_wdata == '0) begin
			eff_count = pam_pkg::CFG_W'(1);
		end else if (int'(cfg_wdata) > MAILBOX_DEPTH) begin
			eff_count = pam_pkg::CFG_W'(MAILBOX_DEPTH);
		end else begin
			eff_count = cfg_wdata;
		end
	end

	// Out-of-range priorities fall to the last, least urgent level.
	assign sp = (int'(pri) >= PRIORITY_LEVELS) ? PRI_W'(PRIORITY_LEVELS - 1) : PRI_W'(pri);

	// Queue tail and head arithmetic, one wrap at most.
	assign tail_sum = QSUM_W'(q_head_q) + QSUM_W'(q_fill_q);
	assign tail = (int'(tail_sum) >= QDEPTH) ? QIDX_W'(tail_sum - QSUM_W'(QDEPTH))
		: QIDX_W'(tail_sum);
	assign head_inc = (int'(q_head_q) == QDEPTH - 1) ? '0 : q_head_q + QIDX_W'(1);

	// The head entry may still be on its way from the waiter RAM.
	assign head_data = (pend_q && pend_slot_q == q_head_q) ? ram_rdata : q_store_q[q_head_q];

	// Parking slot in the ring of the requested priority.
	assign wslot_sum = WSUM_W'(w_head_q[sp]) + WSUM_W'(w_fill_q[sp]);
	assign wslot = (int'(wslot_sum) >= WAIT_DEPTH)
		? WIDX_W'(wslot_sum - WSUM_W'(WAIT_DEPTH)) : WIDX_W'(wslot_sum);

	// Highest waiting priority: the lowest level with a waiter wins.
	always_comb begin
		pick_valid = 1'b0;
		pick_p = '0;
		for (int p = PRIORITY_LEVELS - 1; p >= 0; p--) begin
			if (w_fill_q[p] != '0) begin
				pick_valid = 1'b1;
				pick_p = PRI_W'(p);
			end
		end
	end

	assign pick_head = w_head_q[pick_p];
	assign pick_head_inc = (int'(pick_head) == WAIT_DEPTH - 1) ? '0 : pick_head + WIDX_W'(1);

	// Decision for the word in the input register.
	assign is_send = (cmd == pam_pkg::CMD_SEND);
	assign enq_ok = (free_q != '0) && (int'(q_fill_q) < QDEPTH);
	assign park_ok = (int'(w_fill_q[sp]) < WAIT_DEPTH);
	assign q_empty = (q_fill_q == '0);
	assign do_enq = step && is_send && enq_ok;
	assign do_park = step && is_send && !enq_ok && park_ok;
	assign do_recv = step && !is_send && !q_empty;
	assign do_promote = do_recv && pick_valid;

	// Waiter RAM: parked words are written, a promotion reads the oldest one.
	assign ram_we = do_park;
	assign ram_waddr = WADDR_W'(int'(sp) * WAIT_DEPTH) + WADDR_W'(wslot);
	assign ram_re = do_promote;
	assign ram_raddr = WADDR_W'(int'(pick_p) * WAIT_DEPTH) + WADDR_W'(pick_head);

	pam_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (WENT)
	) u_wait_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (msg),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result word for the current item.
	always_comb begin
		res.status = pam_pkg::ST_REJECTED;
		res.promoted_valid = 1'b0;
		res.promoted_priority = '0;
		msg_out = '0;
		if (is_send) begin
			if (enq_ok) begin
				res.status = pam_pkg::ST_ENQUEUED;
			end else if (park_ok) begin
				res.status = pam_pkg::ST_PARKED;
			end
		end else if (q_empty) begin
			res.status = pam_pkg::ST_EMPTY;
		end else begin
			res.status = pam_pkg::ST_RECEIVED;
			msg_out = head_data;
			res.promoted_valid = pick_valid;
			if (pick_valid) begin
				res.promoted_priority = pam_pkg::PRI_MAX_W'(pick_p);
			end
		end
	end

	// Queue pointers, envelope count and waiter rings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_head_q <= '0;
			q_fill_q <= '0;
			free_q <= pam_pkg::CFG_W'(RST_FREE);
			pend_q <= 1'b0;
			pend_slot_q <= '0;
			for (int p = 0; p < PRIORITY_LEVELS; p++) begin
				w_head_q[p] <= '0;
				w_fill_q[p] <= '0;
			end
		end else if (cfg_we) begin
			q_head_q <= '0;
			q_fill_q <= '0;
			free_q <= eff_count;
			pend_q <= 1'b0;
			for (int p = 0; p < PRIORITY_LEVELS; p++) begin
				w_head_q[p] <= '0;
				w_fill_q[p] <= '0;
			end
		end else begin
			pend_q <= do_promote;
			if (do_promote) begin
				pend_slot_q <= tail;
			end
			if (do_enq) begin
				q_fill_q <= q_fill_q + pam_pkg::CFG_W'(1);
				free_q <= free_q - pam_pkg::CFG_W'(1);
			end
			if (do_park) begin
				w_fill_q[sp] <= w_fill_q[sp] + WCNT_W'(1);
			end
			if (do_recv) begin
				q_head_q <= head_inc;
				if (pick_valid) begin
					w_head_q[pick_p] <= pick_head_inc;
					w_fill_q[pick_p] <= w_fill_q[pick_p] - WCNT_W'(1);
				end else begin
					q_fill_q <= q_fill_q - pam_pkg::CFG_W'(1);
					free_q <= free_q + pam_pkg::CFG_W'(1);
				end
			end
		end
	end

	// Message slots: direct sends, and promoted words in the cycle after promotion.
	always_ff @(posedge clk) begin
		if (do_enq) begin
			q_store_q[tail] <= msg;
		end
		if (pend_q) begin
			q_store_q[pend_slot_q] <= ram_rdata;
		end
	end

endmodule

// ----- src/priority_admission_mailbox_unit.sv -----
// Bounded mailbox with priority wakeup of parked senders.
// Input channel (in_valid / in_stall) carries one request word: cmd selects
// send or receive, priority_req and message_in go with a send. A word is
// taken at a rising edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall) returns exactly one result word per
// request: status, message_out, promoted_valid and promoted_priority.
// The request sits in the input register while the queue and waiter state
// are updated, then its result waits in the output register. One request
// per cycle is sustained while the receiver does not stall; the waiter ring
// RAM delivers a promoted word in the next cycle and a bypass covers it.
// When the receiver stalls, the output word holds and the input register
// fills, after which in_stall rises until the output word is taken.
// cfg_we writes envelope_count and empties the mailbox and all waiter rings;
// the user must write it only while the block is idle; the block does not enforce it.
// Reset empties all queues and sets four envelopes (fewer if the mailbox is
// smaller); no clearing pass is needed.
module priority_admission_mailbox_unit #(
	parameter int MAILBOX_DEPTH = 4,
	parameter int WAIT_DEPTH = 4,
	parameter int PRIORITY_LEVELS = 3,
	parameter int DATA_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pam_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           cmd,
	input  logic [pam_pkg::PRI_PORT_W-1:0] priority_req,
	input  logic signed [DATA_WIDTH-1:0]   message_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [2:0]                     status,
	output logic signed [DATA_WIDTH-1:0]   message_out,
	output logic                           promoted_valid,
	output logic [pam_pkg::PRI_PORT_W-1:0] promoted_priority
);

	logic                           valid_s1;
	logic                           cmd_s1;
	logic [pam_pkg::PRI_PORT_W-1:0] pri_s1;
	logic [DATA_WIDTH-1:0]          msg_s1;
	logic                           valid_s2;
	pam_pkg::result_t               res_s2;
	logic [DATA_WIDTH-1:0]          msg_s2;
	logic                           advance;
	pam_pkg::result_t               res;
	logic [DATA_WIDTH-1:0]          res_msg;

	// The input word moves on whenever the output register is free or draining.
	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1 <= cmd;
			pri_s1 <= priority_req;
			msg_s1 <= message_in;
		end
	end

	pam_ctrl #(
		.MAILBOX_DEPTH   (MAILBOX_DEPTH),
		.WAIT_DEPTH      (WAIT_DEPTH),
		.PRIORITY_LEVELS (PRIORITY_LEVELS),
		.DATA_WIDTH      (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.cmd       (cmd_s1),
		.pri       (pri_s1),
		.msg       (msg_s1),
		.res       (res),
		.msg_out   (res_msg)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
			msg_s2 <= res_msg;
		end
	end

	assign out_valid = valid_s2;
	assign status = res_s2.status;
	assign message_out = msg_s2;
	assign promoted_valid = res_s2.promoted_valid;
	assign promoted_priority = res_s2.promoted_priority[pam_pkg::PRI_PORT_W-1:0];

endmodule

// ----- src/pam_checker.sv -----
`include "priority_admission_mailbox_unit_assert.svh"

module pam_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [2:0]                     status,
	input logic [DATA_WIDTH-1:0]          message_out,
	input logic                           promoted_valid,
	input logic [pam_pkg::PRI_PORT_W-1:0] promoted_priority
);

	// A stalled result word stays put.
	`PAM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(message_out))

	// Only a receive that took a message can admit a waiting sender.
	`PAM_ASSERT_NOW(a_promo_recv, out_valid && promoted_valid, status == pam_pkg::ST_RECEIVED)

	// Message and priority fields read zero where they carry nothing.
	`PAM_ASSERT_NOW(a_msg_zero, out_valid && status != pam_pkg::ST_RECEIVED, message_out == '0)
	`PAM_ASSERT_NOW(a_pri_zero, out_valid && !promoted_valid, promoted_priority == '0)

	// No result is offered while reset is held.
	`PAM_ASSERT_ALWAYS(a_rst_idle, !arst_n, !out_valid)

endmodule

bind priority_admission_mailbox_unit pam_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_pam_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.status            (status),
	.message_out       (message_out),
	.promoted_valid    (promoted_valid),
	.promoted_priority (promoted_priority)
);

// ----- sim/priority_admission_mailbox_unit_tb.sv -----
`timescale 1ns / 100ps

module priority_admission_mailbox_unit_tb;

	localparam int SLOTS = 4;
	localparam int WAITS = 4;
	localparam int LEVELS = 3;

	// One result word as the block should return it.
	typedef struct {
		pam_pkg::status_t status;
		logic [31:0]      msg;
		logic             pv;
		logic [1:0]       pp;
	} outcome_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [pam_pkg::CFG_W-1:0] cfg_wdata;
	logic                      in_valid;
	logic                      in_stall;
	logic                      cmd;
	logic [1:0]                priority_req;
	logic signed [31:0]        message_in;
	logic                      out_valid;
	logic                      out_stall;
	logic [2:0]                status;
	logic signed [31:0]        message_out;
	logic                      promoted_valid;
	logic [1:0]                promoted_priority;

	outcome_t outcomes_due[$];
	int       errors = 0;
	bit       idle_on = 1'b1;

	// Shadow copy of the mailbox: message ring, envelopes and one waiter ring per level.
	logic [31:0] queued_msg[SLOTS];
	int          q_head;
	int          q_fill;
	int          free_env;
	logic [31:0] parked_msg[LEVELS][WAITS];
	int          park_head[LEVELS];
	int          park_fill[LEVELS];

	priority_admission_mailbox_unit DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.priority_req     (priority_req),
		.message_in       (message_in),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.message_out      (message_out),
		.promoted_valid   (promoted_valid),
		.promoted_priority(promoted_priority)
	);

	// Clock and the single reset at the start of the run.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Hard limit on the length of the run.
	initial begin
		#5_000_000;
		$display("FAIL priority_admission_mailbox_unit");
		$finish;
	end

	// Empties every queue and hands out the envelopes of the new count.
	function automatic void clear_mailbox(input logic [pam_pkg::CFG_W-1:0] count);
		q_head = 0;
		q_fill = 0;
		for (int l = 0; l < LEVELS; l++) begin
			park_head[l] = 0;
			park_fill[l] = 0;
		end
		if (count == 0) begin
			free_env = 1;
		end else if (count > SLOTS) begin
			free_env = SLOTS;
		end else begin
			free_env = count;
		end
	endfunction

	// Applies one request to the shadow mailbox and returns the word it should produce.
	function automatic outcome_t serve_request(input logic c, input logic [1:0] p_in,
			input logic [31:0] m);
		outcome_t r;
		int       lvl;
		r.status = pam_pkg::ST_EMPTY;
		r.msg = '0;
		r.pv = 1'b0;
		r.pp = 2'd0;
		if (c == pam_pkg::CMD_SEND) begin
			// Priorities beyond the last level fall into the last, least urgent one.
			lvl = (p_in >= LEVELS) ? LEVELS - 1 : p_in;
			if (free_env > 0 && q_fill < SLOTS) begin
				free_env--;
				queued_msg[(q_head + q_fill) % SLOTS] = m;
				q_fill++;
				r.status = pam_pkg::ST_ENQUEUED;
			end else if (park_fill[lvl] < WAITS) begin
				parked_msg[lvl][(park_head[lvl] + park_fill[lvl]) % WAITS] = m;
				park_fill[lvl]++;
				r.status = pam_pkg::ST_PARKED;
			end else begin
				r.status = pam_pkg::ST_REJECTED;
			end
		end else if (q_fill != 0) begin
			r.status = pam_pkg::ST_RECEIVED;
			r.msg = queued_msg[q_head];
			q_head = (q_head + 1) % SLOTS;
			q_fill--;
			free_env++;
			// The freed envelope goes to the oldest waiter of the most urgent level.
			for (lvl = 0; lvl < LEVELS; lvl++) begin
				if (!r.pv && park_fill[lvl] > 0) begin
					queued_msg[(q_head + q_fill) % SLOTS] = parked_msg[lvl][park_head[lvl]];
					q_fill++;
					free_env--;
					park_head[lvl] = (park_head[lvl] + 1) % WAITS;
					park_fill[lvl]--;
					r.pv = 1'b1;
					r.pp = lvl[1:0];
				end
			end
		end
		return r;
	endfunction

	// Tracks register writes and accepted request words.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_mailbox(3'd4);
			outcomes_due.delete();
		end else if (cfg_we) begin
			clear_mailbox(cfg_wdata);
		end else if (in_valid && !in_stall) begin
			outcomes_due.push_back(serve_request(cmd, priority_req, message_in));
		end
	end

	// Compares each accepted result word with the oldest prediction.
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (outcomes_due.size() == 0) begin
				$error("result word with no request outstanding");
				errors++;
			end else begin
				want = outcomes_due.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					errors++;
				end
				if (message_out !== want.msg) begin
					$error("message_out: expected %h, actual %h", want.msg, message_out);
					errors++;
				end
				if (promoted_valid !== want.pv) begin
					$error("promoted_valid: expected %0d, actual %0d", want.pv, promoted_valid);
					errors++;
				end
				if (promoted_priority !== want.pp) begin
					$error("promoted_priority: expected %0d, actual %0d", want.pp,
						promoted_priority);
					errors++;
				end
			end
		end
	end

	// Receiver stalls in short random bursts while idling is enabled.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	// Message words weighted towards the extremes.
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	// Presents one request word and returns at the edge where it is taken.
	task automatic put_request(input logic c, input logic [1:0] p, input logic [31:0] m);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		priority_req <= p;
		message_in <= m;
		do @(posedge clk); while (in_stall);
	endtask

	// Stops sending and waits until every outstanding result has come back.
	task automatic settle();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (outcomes_due.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic set_envelopes(input logic [pam_pkg::CFG_W-1:0] count);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_traffic(input int n, input int send_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < send_pct) begin
				put_request(pam_pkg::CMD_SEND, 2'($urandom_range(0, 3)), rand_word());
			end else begin
				put_request(pam_pkg::CMD_RECV, 2'($urandom_range(0, 3)), rand_word());
			end
		end
	endtask

	// From reset: empty receive, filling the mailbox, parking at every level,
	// a full waiter ring, and promotions in priority order until empty again.
	task automatic test_directed();
		put_request(pam_pkg::CMD_RECV, 2'd0, 32'h0);
		put_request(pam_pkg::CMD_SEND, 2'd0, 32'h8000_0000);
		put_request(pam_pkg::CMD_SEND, 2'd1, 32'h7fff_ffff);
		put_request(pam_pkg::CMD_SEND, 2'd2, 32'h0000_0000);
		put_request(pam_pkg::CMD_SEND, 2'd3, 32'hffff_ffff);
		for (int i = 0; i < 5; i++) begin
			put_request(pam_pkg::CMD_SEND, 2'd3, rand_word());
		end
		put_request(pam_pkg::CMD_SEND, 2'd1, 32'h1234_5678);
		put_request(pam_pkg::CMD_SEND, 2'd0, 32'hdead_beef);
		for (int i = 0; i < 11; i++) begin
			put_request(pam_pkg::CMD_RECV, 2'd3, 32'hffff_ffff);
		end
	endtask

	// Every envelope count, including the ones that are clamped.
	task automatic test_envelope_settings();
		logic [pam_pkg::CFG_W-1:0] counts[8] = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd5, 3'd6,
			3'd4};
		foreach (counts[i]) begin
			set_envelopes(counts[i]);
			run_traffic(30, 60);
		end
	endtask

	// Phases of mixed traffic with a random count and send bias each time.
	task automatic test_random_traffic();
		int bias[3] = '{25, 50, 75};
		for (int ph = 0; ph < 8; ph++) begin
			set_envelopes(pam_pkg::CFG_W'($urandom_range(0, 7)));
			idle_on = ($urandom_range(0, 3) != 0);
			run_traffic(100, bias[$urandom_range(0, 2)]);
		end
	endtask

	// Back-to-back words with neither side idling.
	task automatic test_full_rate();
		idle_on = 1'b0;
		set_envelopes(3'd4);
		run_traffic(100, 55);
	endtask

	initial begin
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		cmd <= pam_pkg::CMD_SEND;
		priority_req <= '0;
		message_in <= '0;
		wait (arst_n);
		@(posedge clk);
		test_directed();
		test_envelope_settings();
		test_random_traffic();
		test_full_rate();
		settle();
		if (outcomes_due.size() != 0) begin
			$error("%0d result words never arrived", outcomes_due.size());
			errors++;
		end
		repeat (6) @(posedge clk);
		if (errors == 0) begin
			$display("PASS priority_admission_mailbox_unit");
		end else begin
			$display("FAIL priority_admission_mailbox_unit");
		end
		$finish;
	end

endmodule
